// ----- rtl/core/ccs_pkg.sv -----
// ============================================================================
// ccs_pkg - shared types and constants of the closed cardinal spline evaluator
// Command codes, fixed field widths and the control word passed front to back.
// ============================================================================
package ccs_pkg;

    typedef enum logic [1:0]
    {
        CMD_LOAD   = 2'd0,
        CMD_POINT  = 2'd1,
        CMD_DERIV1 = 2'd2,
        CMD_DERIV2 = 2'd3
    } cmd_t;

    localparam int NW         = 9;          // point count width
    localparam int TW         = 17;         // t parameter, Q0.16 plus the 1.0 bit
    localparam int FW         = 16;         // fraction width
    localparam int SW         = 15;         // tension, Q3.12
    localparam int SLOTW      = 8;          // load slot width
    localparam int AVW        = 22;         // s-coefficient of a basis column
    localparam int WW         = 38;         // weight before n scaling, Q.28
    localparam int SCW        = 2 * NW;     // scale factor, up to n squared
    localparam int WSW        = WW + SCW;   // scaled weight
    localparam int LOW        = 27;         // low slice of a scaled weight
    localparam int HIW        = WSW - LOW;  // high, signed slice
    localparam int FRAC_SHIFT = 28;         // Q.44 down to Q.16

    typedef struct packed
    {
        logic              is_load;
        cmd_t              cmd;
        logic [NW-1:0]     seg;
        logic [FW-1:0]     uf;
        logic [SLOTW-1:0]  slot;
    } ccs_ctl_t;

endpackage

// ----- rtl/core/ccs_in_if.sv -----
// ============================================================================
// ccs_in_if - command channel
// valid/ready channel carrying one command beat.
// ============================================================================
interface ccs_in_if #(parameter int CW = 32);
    logic                 valid;
    logic                 ready;
    logic [1:0]           command;
    logic [7:0]           point_index;
    logic signed [CW-1:0] coord_x;
    logic signed [CW-1:0] coord_y;
    logic signed [CW-1:0] coord_z;
    logic [16:0]          t_param;

    modport source (output valid, command, point_index, coord_x, coord_y, coord_z,
                    t_param, input ready);
    modport sink   (input valid, command, point_index, coord_x, coord_y, coord_z,
                    t_param, output ready);
endinterface

// ----- rtl/core/ccs_out_if.sv -----
// ============================================================================
// ccs_out_if - result channel
// valid/ready channel carrying one result beat.
// ============================================================================
interface ccs_out_if #(parameter int CW = 32);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_z;
    logic                 status;

    modport source (output valid, out_x, out_y, out_z, status, input ready);
    modport sink   (input valid, out_x, out_y, out_z, status, output ready);
endinterface

// ----- rtl/core/ccs_front.sv -----
// ============================================================================
// ccs_front - command intake
// Accepts beats, splits t*n into segment and fraction, pushes to the queue.
// ============================================================================
module ccs_front #(
    parameter int CW = 32
) (
    ccs_in_if.sink                  in_ch,
    input  logic [ccs_pkg::NW-1:0]  n_eff,
    input  logic                    q_full,
    output logic                    q_push,
    output ccs_pkg::ccs_ctl_t       q_ctl,
    output logic [2:0][CW-1:0]      q_pts
);
    import ccs_pkg::*;

    logic [TW+NW-1:0] prod;
    logic [TW+NW-1:FW] whole;

    assign in_ch.ready = !q_full;
    assign q_push      = in_ch.valid && !q_full;

    assign prod  = in_ch.t_param * n_eff;
    assign whole = prod[TW+NW-1:FW];

    always_comb
    begin
        q_ctl.is_load = (cmd_t'(in_ch.command) == CMD_LOAD);
        q_ctl.cmd     = cmd_t'(in_ch.command);
        // whole part never exceeds n, so one compare does the wrap
        q_ctl.seg     = (whole >= {1'b0, n_eff}) ? '0 : whole[FW+NW-1:FW];
        q_ctl.uf      = prod[FW-1:0];
        q_ctl.slot    = in_ch.point_index;
    end

    assign q_pts = {in_ch.coord_x, in_ch.coord_y, in_ch.coord_z};

endmodule

// ----- rtl/core/ccs_queue.sv -----
// ============================================================================
// ccs_queue - small FIFO between front and back
// Register-based, power-of-two depth, head visible combinationally.
// ============================================================================
module ccs_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         full,
    output logic         empty
);
    localparam int PW = $clog2(DEPTH);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wp_reg;
    logic [PW-1:0] rp_reg;
    logic [PW:0]   cnt_reg;

    assign full  = (cnt_reg == (PW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wdata;
    end

endmodule

// ----- rtl/core/ccs_ram.sv -----
// ============================================================================
// ccs_ram - control point store
// One write port, two registered read ports.
// ============================================================================
module ccs_ram #(
    parameter int DEPTH = 256,
    parameter int W     = 96
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [W-1:0]             rdata_a,
    output logic [W-1:0]             rdata_b
);
    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ----- rtl/core/ccs_back.sv -----
// ============================================================================
// ccs_back - evaluation pipeline
// Loads write the store; evaluations fetch four neighbours, build the
// weights and run the weighted sum, round and saturate.
// ============================================================================
module ccs_back #(
    parameter int CW         = 32,
    parameter int MAX_POINTS = 256
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_empty,
    input  ccs_pkg::ccs_ctl_t        q_ctl,
    input  logic [2:0][CW-1:0]       q_pts,
    output logic                     q_pop,
    input  logic [ccs_pkg::NW-1:0]   n_eff,
    input  logic [ccs_pkg::SCW-1:0]  n_sq,
    input  logic [ccs_pkg::SW-1:0]   tension,
    ccs_out_if.source                out_ch
);
    import ccs_pkg::*;

    localparam int IW   = $clog2(MAX_POINTS);
    localparam int PLW  = CW + LOW + 1;
    localparam int PHW  = CW + HIW;
    localparam int ACCW = CW + WSW + 3;
    localparam int RW   = ACCW - FRAC_SHIFT;
    localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

    logic adv;

    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic e_valid_reg, f_valid_reg, g_valid_reg, out_valid_reg;

    ccs_ctl_t           a_ctl_reg;
    logic [2:0][CW-1:0] a_pts_reg;

    ccs_ctl_t           b_ctl_reg;
    logic [2:0][CW-1:0] b_pts_reg;
    logic [FW-1:0]      b_u2_reg;
    logic [NW-1:0]      b_idx_reg [4];

    cmd_t               c_cmd_reg;
    logic [FW-1:0]      c_uf_reg, c_u2_reg, c_u3_reg;
    logic [3*CW-1:0]    rd0, rd1, rd2, rd3;

    logic signed [AVW-1:0] d_a0_reg, d_a1_reg;
    logic signed [WW-1:0]  d_c1_reg, d_c2_reg;
    logic [SCW-1:0]        d_scale_reg;
    logic [3:0][2:0][CW-1:0] d_pts_reg;

    logic signed [WW-1:0]  e_p0_reg, e_p1_reg, e_c1_reg, e_c2_reg;
    logic [SCW-1:0]        e_scale_reg;
    logic [3:0][2:0][CW-1:0] e_pts_reg;

    logic signed [WSW-1:0] f_ws_reg [4];
    logic [3:0][2:0][CW-1:0] f_pts_reg;

    logic signed [PLW-1:0] g_pl_reg [3][4];
    logic signed [PHW-1:0] g_ph_reg [3][4];

    logic [2:0][CW-1:0] out_val_reg;
    logic               out_sat_reg;

    // combinational next values
    logic [NW-1:0]         idx_next [4];
    logic [FW-1:0]         u2_next, u3_next;
    logic signed [AVW-1:0] a0_next, a1_next;
    logic signed [WW-1:0]  c1_next, c2_next;
    logic [SCW-1:0]        scale_next;
    logic signed [WW-1:0]  p0_next, p1_next;
    logic signed [WSW-1:0] ws_next [4];
    logic signed [PLW-1:0] pl_next [3][4];
    logic signed [PHW-1:0] ph_next [3][4];
    logic [2:0][CW-1:0]    val_next;
    logic                  sat_next;
    logic                  slot_ok;

    // whole pipe moves together; the output register parts it from the sink
    assign adv   = !out_valid_reg || out_ch.ready;
    assign q_pop = adv && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            f_valid_reg   <= 1'b0;
            g_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= !q_empty;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg && !b_ctl_reg.is_load;
            d_valid_reg   <= c_valid_reg;
            e_valid_reg   <= d_valid_reg;
            f_valid_reg   <= e_valid_reg;
            g_valid_reg   <= f_valid_reg;
            out_valid_reg <= g_valid_reg;
        end
    end

    // stage A: neighbour indices and u^2
    always_comb
    begin
        logic [2*FW-1:0] sq;
        logic [NW-1:0]   seg;
        logic [NW-1:0]   nx1;
        logic [NW-1:0]   nx2;
        seg = a_ctl_reg.seg;
        nx1 = seg + NW'(1);
        idx_next[0] = (seg == '0) ? n_eff - NW'(1) : seg - NW'(1);
        idx_next[1] = seg;
        idx_next[2] = (nx1 == n_eff) ? '0 : nx1;
        nx2 = idx_next[2] + NW'(1);
        idx_next[3] = (nx2 == n_eff) ? '0 : nx2;
        sq = a_ctl_reg.uf * a_ctl_reg.uf + (2*FW)'(32768);
        u2_next = sq[2*FW-1:FW];
    end

    // stage B: store access and u^3
    always_comb
    begin
        logic [2*FW-1:0] cu;
        cu = b_u2_reg * b_ctl_reg.uf + (2*FW)'(32768);
        u3_next = cu[2*FW-1:FW];
    end

    assign slot_ok = (int'(b_ctl_reg.slot) < MAX_POINTS);

    ccs_ram #(.DEPTH(MAX_POINTS), .W(3*CW)) u_ram_lo (
        .clk     (clk),
        .we      (adv && b_valid_reg && b_ctl_reg.is_load && slot_ok),
        .waddr   (IW'(b_ctl_reg.slot)),
        .wdata   (b_pts_reg),
        .re      (adv),
        .raddr_a (IW'(b_idx_reg[0])),
        .raddr_b (IW'(b_idx_reg[1])),
        .rdata_a (rd0),
        .rdata_b (rd1)
    );

    ccs_ram #(.DEPTH(MAX_POINTS), .W(3*CW)) u_ram_hi (
        .clk     (clk),
        .we      (adv && b_valid_reg && b_ctl_reg.is_load && slot_ok),
        .waddr   (IW'(b_ctl_reg.slot)),
        .wdata   (b_pts_reg),
        .re      (adv),
        .raddr_a (IW'(b_idx_reg[2])),
        .raddr_b (IW'(b_idx_reg[3])),
        .rdata_a (rd2),
        .rdata_b (rd3)
    );

    // stage C: power vector folded into the basis matrix.
    // Each column is (tension term) * s + constant term.
    always_comb
    begin
        logic signed [WW-1:0] uv0, uv1, uv2, uv3, a0, a1;
        unique case (c_cmd_reg)
            CMD_DERIV1:
            begin
                uv0 = $signed(WW'(c_u2_reg)) * 3;
                uv1 = $signed(WW'(c_uf_reg)) <<< 1;
                uv2 = $signed(WW'(1)) <<< FW;
                uv3 = '0;
                scale_next = SCW'(n_eff);
            end
            CMD_DERIV2:
            begin
                uv0 = $signed(WW'(c_uf_reg)) * 6;
                uv1 = $signed(WW'(1)) <<< (FW+1);
                uv2 = '0;
                uv3 = '0;
                scale_next = n_sq;
            end
            default:
            begin
                uv0 = $signed(WW'(c_u3_reg));
                uv1 = $signed(WW'(c_u2_reg));
                uv2 = $signed(WW'(c_uf_reg));
                uv3 = $signed(WW'(1)) <<< FW;
                scale_next = SCW'(1);
            end
        endcase
        a0 = (uv1 <<< 1) - uv0 - uv2;
        a1 = uv1 - uv0;
        a0_next = AVW'(a0);
        a1_next = AVW'(a1);
        c1_next = (uv0 <<< 13) - (uv1 <<< 13) - (uv1 <<< 12) + (uv3 <<< 12);
        c2_next = (uv1 <<< 13) + (uv1 <<< 12) - (uv0 <<< 13);
    end

    // stage D: tension products
    assign p0_next = $signed({1'b0, tension}) * d_a0_reg;
    assign p1_next = $signed({1'b0, tension}) * d_a1_reg;

    // stage E: column weights, scaled by 1, n or n^2
    always_comb
    begin
        logic signed [WW-1:0]    w [4];
        logic signed [WW+SCW:0]  wsf;
        w[0] = e_p0_reg;
        w[1] = e_p1_reg + e_c1_reg;
        w[2] = e_c2_reg - e_p0_reg;
        w[3] = -e_p1_reg;
        for (int j = 0; j < 4; j++)
        begin
            wsf = w[j] * $signed({1'b0, e_scale_reg});
            ws_next[j] = wsf[WSW-1:0];
        end
    end

    // stage F: coordinate by weight as two partial products
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                pl_next[a][j] = $signed(f_pts_reg[j][a]) * $signed({1'b0, f_ws_reg[j][LOW-1:0]});
                ph_next[a][j] = $signed(f_pts_reg[j][a]) * $signed(f_ws_reg[j][WSW-1:LOW]);
            end
        end
    end

    // stage G: sum, round half up, saturate
    always_comb
    begin
        logic signed [ACCW-1:0] acc;
        logic [RW-1:0]          rnd;
        logic                   fits;
        sat_next = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            acc = $signed(ACCW'(1)) <<< (FRAC_SHIFT - 1);
            for (int j = 0; j < 4; j++)
                acc = acc + (ACCW'(g_ph_reg[a][j]) <<< LOW) + ACCW'(g_pl_reg[a][j]);
            rnd  = acc[ACCW-1:FRAC_SHIFT];
            fits = (&rnd[RW-1:CW-1]) || !(|rnd[RW-1:CW-1]);
            val_next[a] = fits ? rnd[CW-1:0] : (rnd[RW-1] ? MINV : MAXV);
            sat_next    = sat_next || !fits;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_ctl_reg   <= q_ctl;
            a_pts_reg   <= q_pts;

            b_ctl_reg   <= a_ctl_reg;
            b_pts_reg   <= a_pts_reg;
            b_u2_reg    <= u2_next;
            for (int j = 0; j < 4; j++)
                b_idx_reg[j] <= idx_next[j];

            c_cmd_reg   <= b_ctl_reg.cmd;
            c_uf_reg    <= b_ctl_reg.uf;
            c_u2_reg    <= b_u2_reg;
            c_u3_reg    <= u3_next;

            d_a0_reg    <= a0_next;
            d_a1_reg    <= a1_next;
            d_c1_reg    <= c1_next;
            d_c2_reg    <= c2_next;
            d_scale_reg <= scale_next;
            d_pts_reg   <= {rd3, rd2, rd1, rd0};

            e_p0_reg    <= p0_next;
            e_p1_reg    <= p1_next;
            e_c1_reg    <= d_c1_reg;
            e_c2_reg    <= d_c2_reg;
            e_scale_reg <= d_scale_reg;
            e_pts_reg   <= d_pts_reg;

            for (int j = 0; j < 4; j++)
                f_ws_reg[j] <= ws_next[j];
            f_pts_reg   <= e_pts_reg;

            for (int a = 0; a < 3; a++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    g_pl_reg[a][j] <= pl_next[a][j];
                    g_ph_reg[a][j] <= ph_next[a][j];
                end
            end

            out_val_reg <= val_next;
            out_sat_reg <= sat_next;
        end
    end

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.out_x  = out_val_reg[2];
    assign out_ch.out_y  = out_val_reg[1];
    assign out_ch.out_z  = out_val_reg[0];
    assign out_ch.status = out_sat_reg;

endmodule

// ----- rtl/core/closed_cardinal_spline_eval.sv -----
// ============================================================================
// closed_cardinal_spline_eval - closed cardinal spline evaluator
// Ring of 3D control points; returns point, first or second derivative at t.
// ============================================================================
//
//  channel  dir  handshake           beat
//  in_ch    in   valid/ready         command, point_index, coord_x/y/z, t_param
//  out_ch   out  valid/ready         out_x/y/z, status (evaluations only)
//  apb      in   psel/penable/pwrite point_count @0x0, tension @0x4
//
//  One beat per cycle sustained while the result side accepts; an evaluation's
//  result beat passes through the queue, then stages A..G and the output
//  register of the back pipeline before it is presented.
//  Loads write the store in pipe order, so a later evaluation sees them.
//  A 4-entry queue lets intake continue while the result side stalls.
//  Reset clears control state only; no clearing pass on the point store.
//
module closed_cardinal_spline_eval #(
    parameter int MAX_POINTS  = 256,
    parameter int COORD_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    ccs_in_if.sink      in_ch,
    ccs_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ccs_pkg::*;

    localparam int QW   = $bits(ccs_ctl_t) + 3*COORD_WIDTH;
    localparam int NMAX = (MAX_POINTS < 511) ? MAX_POINTS : 511;
    localparam logic [NW-1:0] NMAX_V = NMAX[NW-1:0];
    localparam logic REG_POINT_COUNT = 1'b0;
    localparam logic REG_TENSION     = 1'b1;
    localparam logic [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic [NW-1:0]  point_count_reg;
    logic [SW-1:0]  tension_reg;
    logic [SCW-1:0] nsq_reg;
    logic [NW-1:0]  n_eff;
    logic [4:0]     inflight_reg;

    logic                    q_push, q_pop, q_full, q_empty;
    ccs_ctl_t                f_ctl, h_ctl;
    logic [2:0][COORD_WIDTH-1:0] f_pts, h_pts;
    logic [QW-1:0]           q_rdata;

    assign pready = 1'b1;

    always_comb
    begin
        if (point_count_reg == '0)
            n_eff = NW'(1);
        else if (int'(point_count_reg) > NMAX)
            n_eff = NMAX_V;
        else
            n_eff = point_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= NW'(4);
            tension_reg     <= SW'(2048);
            nsq_reg         <= SCW'(16);
            inflight_reg    <= '0;
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                unique case (paddr[2])
                    REG_POINT_COUNT: point_count_reg <= pwdata[NW-1:0];
                    REG_TENSION:     tension_reg     <= pwdata[SW-1:0];
                endcase
            end
            nsq_reg <= n_eff * n_eff;
            inflight_reg <= inflight_reg
                + 5'(in_ch.valid && in_ch.ready && (cmd_t'(in_ch.command) != CMD_LOAD))
                - 5'(out_ch.valid && out_ch.ready);
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_POINT_COUNT: prdata = {{(32-NW){1'b0}}, point_count_reg};
            REG_TENSION:     prdata = {{(32-SW){1'b0}}, tension_reg};
        endcase
    end

    ccs_front #(.CW(COORD_WIDTH)) u_front (
        .in_ch  (in_ch),
        .n_eff  (n_eff),
        .q_full (q_full),
        .q_push (q_push),
        .q_ctl  (f_ctl),
        .q_pts  (f_pts)
    );

    ccs_queue #(.W(QW), .DEPTH(4)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata ({f_ctl, f_pts}),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    assign {h_ctl, h_pts} = q_rdata;

    ccs_back #(.CW(COORD_WIDTH), .MAX_POINTS(MAX_POINTS)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_ctl   (h_ctl),
        .q_pts   (h_pts),
        .q_pop   (q_pop),
        .n_eff   (n_eff),
        .n_sq    (nsq_reg),
        .tension (tension_reg),
        .out_ch  (out_ch)
    );

    // a result beat needs an evaluation still owed
    a_result_owed: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> inflight_reg != '0)
        else $error("result beat with no evaluation in flight");

    // saturation flag only when some coordinate sits on a rail
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status) |->
            (out_ch.out_x == CMAX || out_ch.out_x == CMIN ||
             out_ch.out_y == CMAX || out_ch.out_y == CMIN ||
             out_ch.out_z == CMAX || out_ch.out_z == CMIN))
        else $error("status set without a saturated coordinate");

    // queue only drains into the back pipe when it holds something
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

endmodule
